/* src/ftcd_pkg.sv */
// Shared types and constants of the fan tier controller.
`default_nettype none
package ftcd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int TEMP_W     = 19;
	localparam int TIME_W     = 32;
	localparam int TIER_W     = 3;
	localparam int DUTY_W     = 8;
	localparam int DIV_CNT_W  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MED_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_TABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_DELAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DITH_PER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DITH_DWELL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DITH_BOUND = 3'd6;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEL,
		ST_MOD,
		ST_MUL,
		ST_QUO,
		ST_OUT
	} ftcd_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic mod_start;
		logic mul;
		logic div_step;
		logic out_load;
	} ftcd_cmd_t;

	typedef struct packed {
		logic dither;
		logic div_last;
	} ftcd_sts_t;

endpackage
`default_nettype wire

/* src/ftcd_in_if.sv */
// Sample channel: temperature and timestamp word.
`default_nettype none
interface ftcd_in_if;
	import ftcd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature;
	logic [TIME_W-1:0]        now_time;

	modport source (output valid, output temperature, output now_time, input ready);
	modport sink (input valid, input temperature, input now_time, output ready);
endinterface
`default_nettype wire

/* src/ftcd_out_if.sv */
// Result channel: tier and duty word.
`default_nettype none
interface ftcd_out_if;
	import ftcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIER_W-1:0] raw_tier;
	logic [TIER_W-1:0] held_tier;
	logic              tier_changed;
	logic [DUTY_W-1:0] duty;

	modport source (output valid, output raw_tier, output held_tier, output tier_changed,
		output duty, input ready);
	modport sink (input valid, input raw_tier, input held_tier, input tier_changed,
		input duty, output ready);
endinterface
`default_nettype wire

/* src/fan_tier_controller_with_dither.sv */
// Fan tier controller top level: controller, datapath and channel wiring.
//
// A sample word (temperature, now_time) enters on the sample channel; one result
// word (raw_tier, held_tier, tier_changed, duty) leaves on the result channel.
// Both channels use valid/ready; a word moves on a clock edge where both are high.
// One sample is in work at a time. Without idle dither a sample passes from
// acceptance through evaluation and tier select to the output state; with dither
// two passes of a shared divider retiring two quotient bits per cycle come
// between select and output: the phase modulo the period, then the slope
// division. The next sample is accepted in the cycle after the result is loaded
// into the output register.
// A result waits in the output register while the receiver stalls, and the block
// still accepts and works on the next sample; that sample's result waits until
// the register is freed.
// The user must write registers through cfg_we, cfg_idx and cfg_wdata only while
// idle; the block does not enforce it. arst_n clears the configuration and tier
// state; the first sample after reset sets the held tier at once.
`default_nettype none
module fan_tier_controller_with_dither
	import ftcd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ftcd_in_if.sink                    sample,
	ftcd_out_if.source                 result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	ftcd_cmd_t cmd;
	ftcd_sts_t sts;

	ftcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ftcd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.temperature  (sample.temperature),
		.now_time     (sample.now_time),
		.cmd          (cmd),
		.sts          (sts),
		.raw_tier     (result.raw_tier),
		.held_tier    (result.held_tier),
		.tier_changed (result.tier_changed),
		.duty         (result.duty)
	);

endmodule
`default_nettype wire

/* src/ftcd_ctrl.sv */
// Sequencing state machine of the fan tier controller.
`default_nettype none
module ftcd_ctrl
	import ftcd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ftcd_sts_t sts,
	output ftcd_cmd_t      cmd
);

	ftcd_state_t state_q;
	ftcd_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_SEL;
			end
			ST_SEL: begin
				if (sts.dither) begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MOD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_QUO;
			end
			ST_QUO: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/ftcd_dp.sv */
// Datapath: registers, tier hysteresis, shared radix-4 divider and duty select.
`default_nettype none
module ftcd_dp
	import ftcd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic signed [TEMP_W-1:0] temperature,
	input  wire logic [TIME_W-1:0]        now_time,
	input  wire ftcd_cmd_t                cmd,
	output ftcd_sts_t                     sts,
	output logic [TIER_W-1:0]             raw_tier,
	output logic [TIER_W-1:0]             held_tier,
	output logic                          tier_changed,
	output logic [DUTY_W-1:0]             duty
);

	logic [35:0] thr_il_q;
	logic [35:0] thr_mh_q;
	logic [39:0] pwm_q;
	logic [15:0] delay_q;
	logic [15:0] period_q;
	logic [15:0] dwell_q;
	logic [15:0] bounds_q;

	logic signed [TEMP_W-1:0] temp_q;
	logic [TIME_W-1:0]        now_q;

	logic              held_v_q;
	logic [TIER_W-1:0] held_q;
	logic              pend_v_q;
	logic [TIER_W-1:0] pend_tgt_q;
	logic [TIME_W-1:0] pend_since_q;
	logic [TIME_W-1:0] idle_t_q;
	logic [TIER_W-1:0] raw_q;
	logic              chg_q;
	logic              dith_q;
	logic              neg_q;

	logic [TIME_W-1:0]    div_d_q;
	logic [15:0]          rem_q;
	logic [15:0]          dvsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [TIER_W-1:0] res_raw_q;
	logic [TIER_W-1:0] res_held_q;
	logic              res_chg_q;
	logic [DUTY_W-1:0] res_duty_q;

	logic              le_idle, le_low, le_med, le_high;
	logic [TIER_W-1:0] raw_d;
	logic              held_v_d;
	logic [TIER_W-1:0] held_d;
	logic              pend_v_d;
	logic [TIER_W-1:0] pend_tgt_d;
	logic [TIME_W-1:0] pend_since_d;
	logic [TIME_W-1:0] idle_t_d;
	logic              chg_d;
	logic [TIME_W-1:0] idle_time;

	logic [16:0] r1, r2;
	logic        ge1, ge2;
	logic [15:0] rem1, rem2;

	logic [15:0] half;
	logic [7:0]  lo, hi, mag;
	logic        rng_neg;
	logic        up;
	logic [15:0] n_mul, den;
	logic [23:0] prod;

	logic [DUTY_W-1:0] tbl_duty;
	logic [DUTY_W-1:0] dith_duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_il_q <= '0;
			thr_mh_q <= '0;
			pwm_q    <= '0;
			delay_q  <= '0;
			period_q <= '0;
			dwell_q  <= '0;
			bounds_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IDLE_LOW:   thr_il_q <= cfg_wdata[35:0];
				REG_MED_HIGH:   thr_mh_q <= cfg_wdata[35:0];
				REG_PWM_TABLE:  pwm_q    <= cfg_wdata[39:0];
				REG_DOWN_DELAY: delay_q  <= cfg_wdata[15:0];
				REG_DITH_PER:   period_q <= cfg_wdata[15:0];
				REG_DITH_DWELL: dwell_q  <= cfg_wdata[15:0];
				REG_DITH_BOUND: bounds_q <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// tier from thresholds; a negative temperature is below every threshold
	always_comb begin
		le_idle = temp_q[TEMP_W-1] || (temp_q[17:0] <= thr_il_q[17:0]);
		le_low  = temp_q[TEMP_W-1] || (temp_q[17:0] <= thr_il_q[35:18]);
		le_med  = temp_q[TEMP_W-1] || (temp_q[17:0] <= thr_mh_q[17:0]);
		le_high = temp_q[TEMP_W-1] || (temp_q[17:0] <= thr_mh_q[35:18]);
		if (le_idle) begin
			raw_d = 3'd0;
		end else if (le_low) begin
			raw_d = 3'd1;
		end else if (le_med) begin
			raw_d = 3'd2;
		end else if (le_high) begin
			raw_d = 3'd3;
		end else begin
			raw_d = 3'd4;
		end
	end

	always_comb begin
		held_v_d     = held_v_q;
		held_d       = held_q;
		pend_v_d     = pend_v_q;
		pend_tgt_d   = pend_tgt_q;
		pend_since_d = pend_since_q;
		chg_d        = 1'b0;
		if (!held_v_q || raw_d > held_q) begin
			held_v_d     = 1'b1;
			held_d       = raw_d;
			pend_v_d     = 1'b0;
			pend_tgt_d   = '0;
			pend_since_d = '0;
			chg_d        = 1'b1;
		end else if (raw_d < held_q) begin
			if (!pend_v_q || pend_tgt_q != raw_d) begin
				pend_v_d     = 1'b1;
				pend_tgt_d   = raw_d;
				pend_since_d = now_q;
			end else if ((now_q - pend_since_q) >= {16'd0, delay_q}) begin
				held_d       = raw_d;
				pend_v_d     = 1'b0;
				pend_tgt_d   = '0;
				pend_since_d = '0;
				chg_d        = 1'b1;
			end
		end else begin
			pend_v_d     = 1'b0;
			pend_tgt_d   = '0;
			pend_since_d = '0;
		end
		if (chg_d && held_d == 3'd0 && (!held_v_q || held_q != 3'd0)) begin
			idle_t_d = now_q;
		end else begin
			idle_t_d = idle_t_q;
		end
	end

	assign idle_time = now_q - idle_t_q;
	assign sts.dither = (held_q == 3'd0) && (period_q[15:1] != 15'd0)
		&& (idle_time >= {16'd0, dwell_q});
	assign sts.div_last = (cnt_q == DIV_LAST_STEP);

	// two restoring steps per cycle
	always_comb begin
		r1   = {rem_q, div_d_q[TIME_W-1]};
		ge1  = (r1 >= {1'b0, dvsr_q});
		rem1 = ge1 ? 16'(r1 - {1'b0, dvsr_q}) : r1[15:0];
		r2   = {rem1, div_d_q[TIME_W-2]};
		ge2  = (r2 >= {1'b0, dvsr_q});
		rem2 = ge2 ? 16'(r2 - {1'b0, dvsr_q}) : r2[15:0];
	end

	// triangle slope: remainder is the phase within the period
	always_comb begin
		half    = {1'b0, period_q[15:1]};
		lo      = bounds_q[7:0];
		hi      = bounds_q[15:8];
		rng_neg = (hi < lo);
		mag     = rng_neg ? (lo - hi) : (hi - lo);
		up      = (rem_q < half);
		n_mul   = up ? rem_q : (period_q - rem_q);
		den     = up ? half : (period_q - half);
		prod    = n_mul * {8'd0, mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_q   <= '0;
			pend_v_q <= 1'b0;
			pend_tgt_q   <= '0;
			pend_since_q <= '0;
			idle_t_q <= '0;
			cnt_q    <= '0;
			dith_q   <= 1'b0;
		end else begin
			if (cmd.eval) begin
				held_v_q     <= held_v_d;
				held_q       <= held_d;
				pend_v_q     <= pend_v_d;
				pend_tgt_q   <= pend_tgt_d;
				pend_since_q <= pend_since_d;
				idle_t_q     <= idle_t_d;
				dith_q       <= 1'b0;
			end
			if (cmd.mod_start) begin
				dith_q <= 1'b1;
			end
			if (cmd.mod_start || cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			temp_q <= temperature;
			now_q  <= now_time;
		end
		if (cmd.eval) begin
			raw_q <= raw_d;
			chg_q <= chg_d;
		end
		if (cmd.mod_start) begin
			div_d_q <= idle_time - {16'd0, dwell_q};
			rem_q   <= '0;
			dvsr_q  <= period_q;
		end else if (cmd.mul) begin
			div_d_q <= {8'd0, prod};
			rem_q   <= '0;
			dvsr_q  <= den;
			neg_q   <= rng_neg;
		end else if (cmd.div_step) begin
			div_d_q <= {div_d_q[TIME_W-3:0], ge1, ge2};
			rem_q   <= rem2;
		end
		if (cmd.out_load) begin
			res_raw_q  <= raw_q;
			res_held_q <= held_q;
			res_chg_q  <= chg_q;
			res_duty_q <= (held_q == 3'd0 && dith_q) ? dith_duty : tbl_duty;
		end
	end

	always_comb begin
		case (held_q)
			3'd0:    tbl_duty = pwm_q[7:0];
			3'd1:    tbl_duty = pwm_q[15:8];
			3'd2:    tbl_duty = pwm_q[23:16];
			3'd3:    tbl_duty = pwm_q[31:24];
			default: tbl_duty = pwm_q[39:32];
		endcase
	end

	assign dith_duty = neg_q ? (bounds_q[7:0] - div_d_q[7:0])
		: (bounds_q[7:0] + div_d_q[7:0]);

	assign raw_tier     = res_raw_q;
	assign held_tier    = res_held_q;
	assign tier_changed = res_chg_q;
	assign duty         = res_duty_q;

endmodule
`default_nettype wire
